FILE: hw/rtl/ipv4_dotted_string_parser_assert.svh
// assertion macros shared by the ipv4 parser modules
// expects clk and arst_n in the scope of the module that uses them
`ifndef IPV4_DOTTED_STRING_PARSER_ASSERT_SVH
`define IPV4_DOTTED_STRING_PARSER_ASSERT_SVH

// property checked on every edge outside reset
`define IPV4P_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition on one edge implies a condition on the next edge
`define IPV4P_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

FILE: hw/rtl/ipv4p_pkg.sv
// types and constants for the ipv4 dotted string parser
// no dependencies
package ipv4p_pkg;

	localparam int OFFSET_BITS_DEF = 12;
	localparam int CH_BITS         = 8;
	localparam int ADDR_BITS       = 32;

	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_START,
		PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} base_t;

	// one character handed from the input stage to the parse core
	typedef struct packed {
		logic       en;
		logic       first;
		logic [7:0] ch;
	} step_t;

	// result control from the core to the output register
	typedef struct packed {
		logic valid;
		logic status;
	} res_ctl_t;

endpackage

FILE: hw/rtl/ipv4_dotted_string_parser.sv
// top level of the ipv4 dotted string parser
// depends on ipv4p_pkg, ipv4p_in_stage, ipv4p_core, ipv4p_out_reg
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata[7:0] ch, s_tuser first_char
// m_       out  m_tvalid/m_tready    m_tdata: status, address, terminator_offset
// cfg_     in   cfg_valid/cfg_ready  cfg_data strict_mode
//
// one character per cycle sustained while m_tready is high; a character is parsed
// while it sits in the input register, and its result (if any) is registered into
// the output register as the character leaves it; the output register holds a
// result while m_tready is low; the input register keeps taking characters until it is itself full
// arst_n clears the parse state, strict mode and both valid flags

module ipv4_dotted_string_parser import ipv4p_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	localparam int TDATA_BITS = ((ADDR_BITS + 1 + OFFSET_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [7:0] ch
	input  logic                  s_tuser,  // [0] first_char
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_BITS-1:0] m_tdata,  // [0] status, [32:1] address, then offset
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data
);

	step_t                  step;
	res_ctl_t               res;
	logic [ADDR_BITS-1:0]   res_addr;
	logic [OFFSET_BITS-1:0] res_offset;
	logic                   advance;

	assign cfg_ready = 1'b1;

	ipv4p_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.step     (step)
	);

	ipv4p_core #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.step       (step),
		.res        (res),
		.res_addr   (res_addr),
		.res_offset (res_offset)
	);

	ipv4p_out_reg #(
		.OFFSET_BITS (OFFSET_BITS),
		.TDATA_BITS  (TDATA_BITS)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.res_addr   (res_addr),
		.res_offset (res_offset),
		.advance    (advance),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

FILE: hw/rtl/ipv4p_in_stage.sv
// input register for the character stream
// depends on ipv4p_pkg
`include "ipv4_dotted_string_parser_assert.svh"

module ipv4p_in_stage import ipv4p_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tuser,
	input  logic       advance,
	output step_t      step
);

	logic       valid_s1;
	logic       first_s1;
	logic [7:0] ch_s1;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1    <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	always_comb begin
		step.en    = valid_s1 && advance;
		step.first = first_s1;
		step.ch    = ch_s1;
	end

	// a held character must not be dropped while the core is blocked
	`IPV4P_ASSERT_NEXT(a_hold_s1, valid_s1 && !advance, valid_s1 && $stable(ch_s1), "character lost while stalled")

endmodule

FILE: hw/rtl/ipv4p_core.sv
// parse state and per-character step logic, plus the strict mode register
// depends on ipv4p_pkg
`include "ipv4_dotted_string_parser_assert.svh"

module ipv4p_core import ipv4p_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_data,
	input  step_t                  step,
	output res_ctl_t               res,
	output logic [ADDR_BITS-1:0]   res_addr,
	output logic [OFFSET_BITS-1:0] res_offset
);

	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	function automatic logic [OFFSET_BITS-1:0] pos_inc(input logic [OFFSET_BITS-1:0] p);
		pos_inc = (p == POS_MAX) ? p : p + 1'b1;
	endfunction

	logic                   strict_q;
	phase_t                 phase_q, phase_d;
	base_t                  base_q, base_d;
	logic [31:0]            pv_q, pv_d;
	logic [1:0]             dc_q, dc_d;
	logic [2:0]             pc_q, pc_d;
	logic [2:0][7:0]        lb_q, lb_d;
	logic                   tb_q, tb_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] ps_q, ps_d;
	logic                   lz_q, lz_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
			phase_q  <= PH_IDLE;
			base_q   <= BASE_DEC;
			pv_q     <= '0;
			dc_q     <= '0;
			pc_q     <= '0;
			lb_q     <= '0;
			tb_q     <= 1'b0;
			pos_q    <= '0;
			ps_q     <= '0;
			lz_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				strict_q <= cfg_data;
			end
			phase_q <= phase_d;
			base_q  <= base_d;
			pv_q    <= pv_d;
			dc_q    <= dc_d;
			pc_q    <= pc_d;
			lb_q    <= lb_d;
			tb_q    <= tb_d;
			pos_q   <= pos_d;
			ps_q    <= ps_d;
			lz_q    <= lz_d;
		end
	end

	always_comb begin
		phase_t                 ph;
		base_t                  base;
		logic [31:0]            pv;
		logic [1:0]             dc;
		logic [2:0]             pc;
		logic [2:0][7:0]        lb;
		logic                   tb;
		logic [OFFSET_BITS-1:0] pos;
		logic [OFFSET_BITS-1:0] ps;
		logic                   lz;
		logic                   active;
		logic                   done;
		logic                   emit;
		logic                   err;
		logic [OFFSET_BITS-1:0] eoff;
		logic [31:0]            addr;
		logic                   is_x;
		logic                   is_zero;
		logic                   is_dec;
		logic                   is_hex_letter;
		logic                   found;
		logic                   in_radix;
		logic [3:0]             dig;
		logic [35:0]            v;
		logic                   too_big_last;

		ph     = phase_q;
		base   = base_q;
		pv     = pv_q;
		dc     = dc_q;
		pc     = pc_q;
		lb     = lb_q;
		tb     = tb_q;
		pos    = pos_q;
		ps     = ps_q;
		lz     = lz_q;
		active = 1'b0;
		done   = 1'b0;
		emit   = 1'b0;
		err    = 1'b0;
		eoff   = '0;
		addr   = '0;
		v      = '0;

		is_x    = (step.ch == CH_LO_X) || (step.ch == CH_UP_X);
		is_zero = (step.ch == CH_ZERO);
		is_dec  = (step.ch >= CH_ZERO) && (step.ch <= CH_NINE);
		is_hex_letter = ((step.ch >= CH_LO_A) && (step.ch <= CH_LO_F)) ||
			((step.ch >= CH_UP_A) && (step.ch <= CH_UP_F));
		dig = is_dec ? step.ch[3:0] : step.ch[3:0] + 4'd9;

		if (step.en) begin
			if (step.first) begin
				ph     = PH_START;
				base   = BASE_DEC;
				pv     = '0;
				dc     = '0;
				pc     = '0;
				lb     = '0;
				tb     = 1'b0;
				ps     = '0;
				lz     = 1'b0;
				pos    = '0;
				active = 1'b1;
			end else if (phase_q != PH_IDLE) begin
				pos    = pos_inc(pos_q);
				active = 1'b1;
			end
		end

		if (active && ph == PH_START) begin
			ps = pos;
			pv = '0;
			dc = '0;
			lz = is_zero;
			ph = PH_DIGITS;
			if (!strict_q && is_zero) begin
				base = BASE_OCT;
				dc   = 2'd1;
				done = 1'b1;
			end else begin
				base = BASE_DEC;
			end
		end

		// "0x" prefix switches the part to hex outside strict mode
		if (active && !done && !strict_q && base == BASE_OCT && dc == 2'd1 && lz && is_x) begin
			base = BASE_HEX;
			dc   = '0;
			pv   = '0;
			done = 1'b1;
		end

		unique case (base)
			BASE_HEX: begin
				found    = is_dec || is_hex_letter;
				in_radix = found;
				v        = {pv, 4'b0} + 36'(dig);
			end
			BASE_OCT: begin
				found    = is_dec;
				in_radix = is_dec && !dig[3];
				v        = {1'b0, pv, 3'b0} + 36'(dig);
			end
			default: begin
				found    = is_dec;
				in_radix = is_dec;
				v        = {1'b0, pv, 3'b0} + {3'b0, pv, 1'b0} + 36'(dig);
			end
		endcase

		unique case (pc)
			3'd3:    too_big_last = |pv[31:8];
			3'd2:    too_big_last = |pv[31:16];
			3'd1:    too_big_last = |pv[31:24];
			default: too_big_last = 1'b0;
		endcase

		if (active && !done) begin
			priority if (found && !in_radix && base == BASE_OCT && dc == 2'd1) begin
				// lone leading zero followed by 8 or 9
				emit = 1'b1;
				err  = 1'b1;
				eoff = pos;
			end else if (found && in_radix) begin
				if (|v[35:32]) begin
					emit = 1'b1;
					err  = 1'b1;
					eoff = pos;
				end else begin
					pv = v[31:0];
					if (dc != 2'd2) begin
						dc = dc + 2'd1;
					end
				end
			end else if (strict_q && dc == 2'd1 && lz && is_x) begin
				emit = 1'b1;
				err  = 1'b1;
				eoff = pos_inc(pos);
			end else if (dc == 2'd0) begin
				// empty part
				emit = 1'b1;
				err  = 1'b1;
				eoff = (step.ch == CH_DOT && pc != 3'd3) ? pos_inc(pos) : pos;
			end else if (strict_q && lz && dc == 2'd2) begin
				emit = 1'b1;
				err  = 1'b1;
				eoff = pos_inc(ps);
			end else if (step.ch == CH_DOT) begin
				if (pc == 3'd3) begin
					emit = 1'b1;
					err  = 1'b1;
					eoff = pos;
				end else begin
					lb[pc[1:0]] = pv[7:0];
					if (|pv[31:8]) begin
						tb = 1'b1;
					end
					pc = pc + 3'd1;
					ph = PH_START;
				end
			end else begin
				// terminator: assemble the address
				emit = 1'b1;
				eoff = pos;
				err  = tb || too_big_last || (strict_q && pc != 3'd3);
				unique case (pc)
					3'd3:    addr = {lb[0], lb[1], lb[2], pv[7:0]};
					3'd2:    addr = {lb[0], lb[1], pv[15:0]};
					3'd1:    addr = {lb[0], pv[23:0]};
					default: addr = pv;
				endcase
			end
		end

		phase_d = emit ? PH_IDLE : ph;
		base_d  = base;
		pv_d    = pv;
		dc_d    = dc;
		pc_d    = pc;
		lb_d    = lb;
		tb_d    = tb;
		pos_d   = pos;
		ps_d    = ps;
		lz_d    = lz;

		res.valid  = emit;
		res.status = err ? STATUS_INVALID : STATUS_OK;
		res_addr   = err ? '0 : addr;
		res_offset = eoff;
	end

	`IPV4P_ASSERT(a_err_zero_addr, !(res.valid && res.status == STATUS_INVALID) || res_addr == '0, "error result with nonzero address")
	`IPV4P_ASSERT(a_pc_range, pc_q <= 3'd3, "part count beyond four parts")
	`IPV4P_ASSERT_NEXT(a_idle_pos, phase_q == PH_IDLE && !(step.en && step.first), $stable(pos_q), "position moved while idle")

endmodule

FILE: hw/rtl/ipv4p_out_reg.sv
// result register driving the output stream
// depends on ipv4p_pkg
`include "ipv4_dotted_string_parser_assert.svh"

module ipv4p_out_reg import ipv4p_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int TDATA_BITS  = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  res_ctl_t               res,
	input  logic [ADDR_BITS-1:0]   res_addr,
	input  logic [OFFSET_BITS-1:0] res_offset,
	output logic                   advance,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_BITS-1:0]  m_tdata
);

	logic                   valid_q;
	logic                   status_q;
	logic [ADDR_BITS-1:0]   addr_q;
	logic [OFFSET_BITS-1:0] offset_q;

	assign advance  = !valid_q || m_tready;
	assign m_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q <= res.status;
			addr_q   <= res_addr;
			offset_q <= res_offset;
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[0] = status_q;
		m_tdata[ADDR_BITS:1] = addr_q;
		m_tdata[ADDR_BITS+1 +: OFFSET_BITS] = offset_q;
	end

	// a taken result with nothing new behind it leaves the register empty
	`IPV4P_ASSERT_NEXT(a_drain, valid_q && m_tready && !res.valid, !valid_q, "result repeated after transfer")

endmodule
